// ===== hdl/integer_matrix_multiply_macros.svh =====
// ---------------------------------------------------------------------------
// Integer matrix multiply assertion macros
// Shared property forms for the checker, clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define IMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer_matrix_multiply check failed");

// The consequent holds in the cycle after the antecedent.
`define IMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer_matrix_multiply check failed");

`endif

// ===== hdl/imm_pkg.sv =====
// ---------------------------------------------------------------------------
// Integer matrix multiply package
// Dimensions, derived widths, item kinds, register indexes and state type.
// ---------------------------------------------------------------------------
package imm_pkg;

  localparam int ROWS  = 8;
  localparam int INNER = 8;
  localparam int COLS  = 8;

  // Most result items one compute item may produce.
  localparam int MAX_RESULTS = 8;
  localparam int MAXC = (COLS < MAX_RESULTS) ? COLS : MAX_RESULTS;

  localparam int A_DEPTH = ROWS * INNER;
  localparam int B_DEPTH = INNER * COLS;
  localparam int A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int KW = (INNER > 1) ? $clog2(INNER) : 1;
  localparam int TW = $clog2(INNER + 1);
  localparam int JW = (MAXC > 1) ? $clog2(MAXC) : 1;
  localparam int NW = $clog2(MAXC + 1);

  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] INNER_LEN_RST = 4'd8;
  localparam logic [CFG_W-1:0] OUT_COLS_RST  = 4'd8;

  localparam logic [0:0] REG_INNER_LEN = 1'b0;
  localparam logic [0:0] REG_OUT_COLS  = 1'b1;

  typedef enum logic [1:0] {
    KIND_WR_A = 2'd0,
    KIND_WR_B = 2'd1,
    KIND_CMP  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } st_t;

endpackage

// ===== hdl/integer_matrix_multiply.sv =====
// Sequencing: a load item is written to the A or B store when it is taken. A
// compute item issues reads for inner_len terms (clamped to 1..8) per column,
// waits for the read, multiply and accumulate registers to drain, then
// registers that result when the output is free, for out_cols columns (1..8).
// Reset: rst_n clears control state and sets inner_len and out_cols to 8;
// the A and B stores are not cleared.
// ---------------------------------------------------------------------------
// Integer matrix multiply
// Stores A and B in on-chip memories and computes one row of C per compute
// item on one shared pipelined multiply-accumulate unit.
// ---------------------------------------------------------------------------
module integer_matrix_multiply import imm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,  // row[2:0], col[5:3], value[21:6], zero fill
  input  logic [1:0]       in_tuser,  // kind[1:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata, // out_row[2:0], out_col[5:3], product[37:6], fill
  output logic             out_tlast
);

  logic [2:0]  in_row;
  logic [2:0]  in_col;
  logic [15:0] in_value;
  kind_t       in_kind;
  logic        in_acc;

  st_t              state_r, state_nxt;
  logic [CFG_W-1:0] inner_len_r, inner_len_nxt;
  logic [CFG_W-1:0] out_cols_r, out_cols_nxt;
  logic [2:0]       row_r, row_nxt;
  logic [TW-1:0]    terms_r, terms_nxt;
  logic [NW-1:0]    ncols_r, ncols_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [JW-1:0]    j_r, j_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [39:0]      out_tdata_r, out_tdata_nxt;
  logic             out_tlast_r, out_tlast_nxt;

  logic              rd_en;
  logic              last_k;
  logic              last_j;
  logic              a_we;
  logic              b_we;
  logic [A_AW-1:0]   a_waddr;
  logic [B_AW-1:0]   b_waddr;
  logic [A_AW-1:0]   a_raddr;
  logic [B_AW-1:0]   b_raddr;

  logic [15:0]        a_mem [A_DEPTH];
  logic [15:0]        b_mem [B_DEPTH];
  logic signed [15:0] a_q_r;
  logic signed [15:0] b_q_r;
  logic               rd_vld_r;
  logic               rd_first_r;
  logic signed [31:0] prod_r;
  logic               mul_vld_r;
  logic               mul_first_r;
  logic [31:0]        acc_r;

  assign in_row   = in_tdata[2:0];
  assign in_col   = in_tdata[5:3];
  assign in_value = in_tdata[21:6];
  assign in_kind  = kind_t'(in_tuser);
  assign in_acc   = in_tvalid && in_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  assign a_we = in_acc && (in_kind == KIND_WR_A) && (int'(in_row) < ROWS)
                && (int'(in_col) < INNER);
  assign b_we = in_acc && (in_kind == KIND_WR_B) && (int'(in_row) < INNER)
                && (int'(in_col) < COLS);
  assign a_waddr = A_AW'(int'(in_row) * INNER + int'(in_col));
  assign b_waddr = B_AW'(int'(in_row) * COLS + int'(in_col));
  assign a_raddr = A_AW'(int'(row_r) * INNER + int'(k_r));
  assign b_raddr = B_AW'(int'(k_r) * COLS + int'(j_r));

  assign last_k = (TW'(k_r) + TW'(1)) == terms_r;
  assign last_j = (NW'(j_r) + NW'(1)) == ncols_r;

  always_comb begin
    state_nxt      = state_r;
    inner_len_nxt  = inner_len_r;
    out_cols_nxt   = out_cols_r;
    row_nxt        = row_r;
    terms_nxt      = terms_r;
    ncols_nxt      = ncols_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    rd_en          = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        REG_INNER_LEN: inner_len_nxt = cfg_data;
        REG_OUT_COLS:  out_cols_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == KIND_CMP) && (int'(in_row) < ROWS)) begin
          row_nxt = in_row;
          if (inner_len_r == '0) begin
            terms_nxt = TW'(1);
          end else if (int'(inner_len_r) > INNER) begin
            terms_nxt = TW'(INNER);
          end else begin
            terms_nxt = TW'(inner_len_r);
          end
          if (out_cols_r == '0) begin
            ncols_nxt = NW'(1);
          end else if (int'(out_cols_r) > MAXC) begin
            ncols_nxt = NW'(MAXC);
          end else begin
            ncols_nxt = NW'(out_cols_r);
          end
          k_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        rd_en = 1'b1;
        if (last_k) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !mul_vld_r && (!out_tvalid_r || out_tready)) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, acc_r, 3'(j_r), row_r};
          out_tlast_nxt  = last_j;
          if (last_j) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + JW'(1);
            state_nxt = ST_ISSUE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      inner_len_r  <= INNER_LEN_RST;
      out_cols_r   <= OUT_COLS_RST;
      out_tvalid_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      mul_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      inner_len_r  <= inner_len_nxt;
      out_cols_r   <= out_cols_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      rd_vld_r     <= rd_en;
      mul_vld_r    <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    terms_r     <= terms_nxt;
    ncols_r     <= ncols_nxt;
    k_r         <= k_nxt;
    j_r         <= j_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_waddr] <= in_value;
    end
    if (b_we) begin
      b_mem[b_waddr] <= in_value;
    end
    if (rd_en) begin
      a_q_r <= a_mem[a_raddr];
      b_q_r <= b_mem[b_raddr];
    end
  end

  // Multiply-accumulate pipeline: read, multiply, accumulate.
  always_ff @(posedge clk) begin
    rd_first_r  <= (k_r == '0);
    prod_r      <= a_q_r * b_q_r;
    mul_first_r <= rd_first_r;
    if (mul_vld_r) begin
      acc_r <= mul_first_r ? prod_r : acc_r + prod_r;
    end
  end

endmodule

// ===== hdl/integer_matrix_multiply_chk.sv =====
// ---------------------------------------------------------------------------
// Integer matrix multiply port checker
// Watches the ports of the top level and is bound to it.
// ---------------------------------------------------------------------------
`include "integer_matrix_multiply_macros.svh"

module integer_matrix_multiply_chk import imm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             cfg_we,
  input logic [0:0]       cfg_index,
  input logic [CFG_W-1:0] cfg_data,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [23:0]      in_tdata,
  input logic [1:0]       in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [39:0]      out_tdata,
  input logic             out_tlast
);

  // A stalled result item holds its payload.
  `IMM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast))

  // While a row is still being emitted, no new item is taken.
  `IMM_ASSERT_NOW(a_busy_mid_row, out_tvalid && !out_tlast, !in_tready)

  // A load item never makes the block busy.
  `IMM_ASSERT_NEXT(a_load_ready, in_tvalid && in_tready && (in_tuser == KIND_WR_A || in_tuser == KIND_WR_B), in_tready)

  // A compute item on a valid row makes the block busy.
  `IMM_ASSERT_NEXT(a_cmp_busy, in_tvalid && in_tready && in_tuser == KIND_CMP && int'(in_tdata[2:0]) < ROWS, !in_tready)

endmodule

bind integer_matrix_multiply integer_matrix_multiply_chk u_chk (.*);
